@@ hdl/hop_channel_list_generator_core_macros.svh @@
// assertion macros shared by the hop channel list generator rtl
// no dependencies; included by files that carry concurrent checks
`ifndef HOP_CHANNEL_LIST_GENERATOR_CORE_MACROS_SVH
`define HOP_CHANNEL_LIST_GENERATOR_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define HCLG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define HCLG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/hclg_pkg.sv @@
// types and constants for the hop channel list generator
// no dependencies; imported by every module of the block
package hclg_pkg;

    localparam logic [31:0] LCG_MUL     = 32'h0019_660D;
    localparam logic [31:0] LCG_ADD     = 32'h3C6E_F35F;
    localparam logic [6:0]  RAW_SPAN    = 7'd73;
    localparam logic [6:0]  CHAN_OFFSET = 7'd3;
    localparam logic [4:0]  LIST_LEN    = 5'd23;
    localparam logic [6:0]  SPLIT_LO    = 7'd25;
    localparam logic [6:0]  SPLIT_HI    = 7'd49;
    localparam logic [3:0]  QUOTA_LO    = 4'd8;
    localparam logic [3:0]  QUOTA_MID   = 4'd7;
    localparam logic [3:0]  QUOTA_HI    = 4'd8;
    // floor(2^30 / 73): quotient estimate is exact or one low for 24-bit x
    localparam logic [23:0] RECIP_73    = 24'd14708792;
    localparam int          RECIP_SHIFT = 30;

    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 24;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int X_W     = 24;
    localparam int Q_W     = 18;

    typedef enum logic [1:0] {
        PART_LO  = 2'd0,
        PART_MID = 2'd1,
        PART_HI  = 2'd2
    } t_part;

    typedef enum logic {
        MUL_LCG   = 1'b0,
        MUL_RECIP = 1'b1
    } t_mul_op;

    typedef struct packed {
        logic    en;
        t_mul_op op;
    } t_mul_ctrl;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_LCG    = 3'd1,
        ST_RECIP  = 3'd2,
        ST_REDUCE = 3'd3,
        ST_CHECK  = 3'd4
    } t_hclg_state;

endpackage

@@ hdl/hclg_mul_unit.sv @@
// shared registered multiply-add: lcg step and reciprocal multiply for mod 73
// depends on hclg_pkg
module hclg_mul_unit (
    input  logic                       i_clk,
    input  hclg_pkg::t_mul_ctrl        i_ctrl,
    input  logic [31:0]                i_seed,
    output logic [hclg_pkg::PROD_W-1:0] o_prod
);
    import hclg_pkg::*;

    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
    logic [31:0]        c;
    logic [PROD_W-1:0]  r_prod;
    logic [PROD_W-1:0]  n_prod;

    // recip operand is the top 24 bits of the lcg state just computed
    always_comb begin
        case (i_ctrl.op)
            MUL_LCG: begin
                a = i_seed;
                b = LCG_MUL[MUL_B_W-1:0];
                c = LCG_ADD;
            end
            default: begin
                a = {8'd0, r_prod[31:8]};
                b = RECIP_73;
                c = 32'd0;
            end
        endcase
        n_prod = PROD_W'(a * b) + {{(PROD_W-32){1'b0}}, c};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

@@ hdl/hclg_reduce.sv @@
// finishes x mod 73 from the quotient estimate and classifies the subrange
// depends on hclg_pkg
module hclg_reduce (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [hclg_pkg::X_W-1:0] i_x,
    input  logic [hclg_pkg::Q_W-1:0] i_q,
    output logic [6:0]             o_raw,
    output hclg_pkg::t_part        o_part
);
    import hclg_pkg::*;

    logic [X_W-1:0] q_ext;
    logic [X_W-1:0] q_times;
    logic [X_W-1:0] diff;
    logic [7:0]     rem8;
    logic [6:0]     n_raw;
    t_part          n_part;
    logic [6:0]     r_raw;
    t_part          r_part;

    always_comb begin
        q_ext   = {{(X_W-Q_W){1'b0}}, i_q};
        // q * 73 as q*64 + q*8 + q
        q_times = (q_ext << 6) + (q_ext << 3) + q_ext;
        diff    = i_x - q_times;
        rem8    = diff[7:0];
        if (rem8 >= {1'b0, RAW_SPAN}) begin
            n_raw = 7'(rem8 - {1'b0, RAW_SPAN});
        end else begin
            n_raw = rem8[6:0];
        end
        if (n_raw < SPLIT_LO) begin
            n_part = PART_LO;
        end else if (n_raw < SPLIT_HI) begin
            n_part = PART_MID;
        end else begin
            n_part = PART_HI;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_raw  <= n_raw;
            r_part <= n_part;
        end
    end

    assign o_raw  = r_raw;
    assign o_part = r_part;

endmodule

@@ hdl/hop_channel_list_generator_core.sv @@
// Hop channel list generator: one 32-bit radio id in, a list of 23 distinct hop channels out,
// in order, slot index 0 to 22, last_slot high on slot 22. The generator is seeded with the
// complement of the id and stepped as state = state * 0x19660D + 0x3C6EF35F; each draw's raw
// value is (state >> 8) mod 73 and is kept only if its parity differs from id bit 0, it is not
// yet in the list and its subrange (0..24, 25..48, 49..72) still has quota (8, 7, 8). Every
// draw goes through one shared registered multiplier twice (lcg step, then the reciprocal
// multiply of the mod 73 reduction), a reduce stage and a check state; a kept draw waits in
// the check state while the result transfer is held off by i_ready. The draw count depends
// on the id. A new id is taken only when the previous list is fully generated; the last
// result may still wait in the output register while the next id is taken.
// depends on hclg_pkg, hclg_mul_unit, hclg_reduce and the assertion macro header
module hop_channel_list_generator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // id channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_radio_id,
    // channel list
    output logic        o_valid,
    input  logic        i_ready,
    output logic [6:0]  o_hop_channel,
    output logic [4:0]  o_slot_index,
    output logic        o_last_slot
);
    import hclg_pkg::*;

`include "hop_channel_list_generator_core_macros.svh"

    // sequencer
    t_hclg_state r_fsm;
    t_hclg_state n_fsm;

    // generator state and per-list bookkeeping
    logic [31:0]       r_seed;
    logic [X_W-1:0]    r_x;
    logic              r_par;
    logic [RAW_SPAN-1:0] r_used;
    logic [3:0]        r_quota_lo;
    logic [3:0]        r_quota_mid;
    logic [3:0]        r_quota_hi;
    logic [4:0]        r_count;

    // output register
    logic              r_ovalid;
    logic [6:0]        r_hop;
    logic [4:0]        r_slot;
    logic              r_last;

    // shared unit hookup
    t_mul_ctrl         mul_ctrl;
    logic [PROD_W-1:0] prod;
    logic              red_en;
    logic [6:0]        raw;
    t_part             part;

    // decode
    logic              start;
    logic              quota_ok;
    logic              keep;
    logic              out_free;
    logic              load_out;
    logic              last_now;

    hclg_mul_unit u_mul (
        .i_clk  (i_clk),
        .i_ctrl (mul_ctrl),
        .i_seed (r_seed),
        .o_prod (prod)
    );

    hclg_reduce u_reduce (
        .i_clk  (i_clk),
        .i_en   (red_en),
        .i_x    (r_x),
        .i_q    (prod[RECIP_SHIFT +: Q_W]),
        .o_raw  (raw),
        .o_part (part)
    );

    // draw acceptance test
    always_comb begin
        case (part)
            PART_LO:  quota_ok = (r_quota_lo != 4'd0);
            PART_MID: quota_ok = (r_quota_mid != 4'd0);
            PART_HI:  quota_ok = (r_quota_hi != 4'd0);
            default:  quota_ok = 1'b0;
        endcase
        keep     = (raw[0] != r_par) && !r_used[raw] && quota_ok;
        out_free = !r_ovalid || i_ready;
        last_now = (r_count == LIST_LEN - 5'd1);
    end

    // next state
    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            ST_IDLE: begin
                if (i_valid) begin
                    n_fsm = ST_LCG;
                end
            end
            ST_LCG:    n_fsm = ST_RECIP;
            ST_RECIP:  n_fsm = ST_REDUCE;
            ST_REDUCE: n_fsm = ST_CHECK;
            ST_CHECK: begin
                if (!keep) begin
                    n_fsm = ST_LCG;
                end else if (out_free) begin
                    n_fsm = last_now ? ST_IDLE : ST_LCG;
                end
            end
            default:   n_fsm = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_ready     = 1'b0;
        mul_ctrl.en = 1'b0;
        mul_ctrl.op = MUL_LCG;
        red_en      = 1'b0;
        load_out    = 1'b0;
        unique case (r_fsm)
            ST_IDLE: begin
                o_ready = 1'b1;
            end
            ST_LCG: begin
                mul_ctrl.en = 1'b1;
                mul_ctrl.op = MUL_LCG;
            end
            ST_RECIP: begin
                mul_ctrl.en = 1'b1;
                mul_ctrl.op = MUL_RECIP;
            end
            ST_REDUCE: begin
                red_en = 1'b1;
            end
            ST_CHECK: begin
                load_out = keep && out_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    assign start = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= ST_IDLE;
            r_ovalid    <= 1'b0;
            r_count     <= 5'd0;
            r_used      <= '0;
            r_quota_lo  <= QUOTA_LO;
            r_quota_mid <= QUOTA_MID;
            r_quota_hi  <= QUOTA_HI;
        end else begin
            r_fsm <= n_fsm;
            if (start) begin
                // fresh list: clear map and counters
                r_count     <= 5'd0;
                r_used      <= '0;
                r_quota_lo  <= QUOTA_LO;
                r_quota_mid <= QUOTA_MID;
                r_quota_hi  <= QUOTA_HI;
            end else if (load_out) begin
                r_count     <= r_count + 5'd1;
                r_used[raw] <= 1'b1;
                case (part)
                    PART_LO:  r_quota_lo  <= r_quota_lo - 4'd1;
                    PART_MID: r_quota_mid <= r_quota_mid - 4'd1;
                    PART_HI:  r_quota_hi  <= r_quota_hi - 4'd1;
                    default:  r_quota_hi  <= r_quota_hi;
                endcase
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_seed <= ~i_radio_id;
            r_par  <= i_radio_id[0];
        end else if (r_fsm == ST_RECIP) begin
            // lcg result is in the multiplier register this cycle
            r_seed <= prod[31:0];
            r_x    <= prod[31:8];
        end
        if (load_out) begin
            r_hop  <= raw + CHAN_OFFSET;
            r_slot <= r_count;
            r_last <= last_now;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_hop_channel = r_hop;
    assign o_slot_index  = r_slot;
    assign o_last_slot   = r_last;

    // every listed channel used exactly one quota unit and one map bit
    `HCLG_ASSERT_NOW(a_quota_total, i_clk, i_rst_n, r_fsm != ST_IDLE, ({1'b0, r_count} + {2'b0, r_quota_lo} + {2'b0, r_quota_mid} + {2'b0, r_quota_hi}) == 6'd23, "quota and slot count disagree")
    `HCLG_ASSERT_NOW(a_map_count, i_clk, i_rst_n, r_fsm != ST_IDLE, $countones(r_used) == 32'(r_count), "used map and slot count disagree")
    `HCLG_ASSERT_NOW(a_raw_range, i_clk, i_rst_n, r_fsm == ST_CHECK, raw < RAW_SPAN, "reduced draw out of range")
    `HCLG_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, load_out && last_now, r_fsm == ST_IDLE && o_valid && o_last_slot, "list did not end on last slot")

endmodule

@@ verif/testbench.sv @@
// self-checking testbench for hop_channel_list_generator_core
// depends on hclg_pkg and the core rtl; a local hop list predictor checks every result transfer
module testbench;
    import hclg_pkg::*;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 64;

    // one expected entry of a hop list
    typedef struct packed {
        logic [6:0] chan;
        logic [4:0] slot;
        logic       last;
    } t_hop_entry;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic [31:0] i_radio_id = '0;
    logic        i_ready    = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [6:0]  o_hop_channel;
    logic [4:0]  o_slot_index;
    logic        o_last_slot;

    t_hop_entry hop_list_q[$];
    t_hop_entry hop_want;
    int         mismatch_count = 0;
    int         cycle_count    = 0;

    // idling knobs, percent of cycles
    int id_idle_pct  = 0;
    int out_stall_pct = 0;

    // long output hold-off, requested by toggling hold_req
    bit hold_req  = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;

    hop_channel_list_generator_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_radio_id    (i_radio_id),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_hop_channel (o_hop_channel),
        .o_slot_index  (o_slot_index),
        .o_last_slot   (o_last_slot)
    );

    always #10 i_clk = ~i_clk;

    // run-length guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // builds the 23-entry hop list for one id and queues it
    task automatic predict_hop_list(input logic [31:0] id);
        logic [31:0] lcg;
        logic [6:0]  raw;
        logic [127:0] used;
        logic [3:0]  quota [3];
        t_part       part;
        int unsigned count;
        t_hop_entry  ent;
        // generator seeded with the complement of the id
        lcg = ~id;
        used = '0;
        quota[PART_LO]  = QUOTA_LO;
        quota[PART_MID] = QUOTA_MID;
        quota[PART_HI]  = QUOTA_HI;
        count = 0;
        while (count < LIST_LEN) begin
            lcg = lcg * LCG_MUL + LCG_ADD;
            raw = 7'((lcg >> 8) % RAW_SPAN);
            // parity must differ from id bit 0
            if (raw[0] == id[0])
                continue;
            if (used[raw])
                continue;
            if (raw < SPLIT_LO)
                part = PART_LO;
            else if (raw < SPLIT_HI)
                part = PART_MID;
            else
                part = PART_HI;
            // subrange already full
            if (quota[part] == 4'd0)
                continue;
            quota[part]--;
            used[raw] = 1'b1;
            ent.chan = raw + CHAN_OFFSET;
            ent.slot = 5'(count);
            ent.last = (count == LIST_LEN - 1);
            hop_list_q.push_back(ent);
            count++;
        end
    endtask

    // offers one id, with random idle cycles first, and waits for its transfer
    task automatic send_id(input logic [31:0] id);
        @(negedge i_clk);
        while ($urandom_range(99) < id_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_radio_id <= id;
        // valid stays up with the same id until the transfer
        do
            @(posedge i_clk);
        while (!o_ready);
        predict_hop_list(id);
    endtask

    task automatic wait_lists_done();
        while (hop_list_q.size() != 0)
            @(posedge i_clk);
    endtask

    // output side: random stalls plus an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else begin
            i_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    // result checker, oldest expected entry first
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (hop_list_q.size() == 0) begin
                $display("%0t: unexpected result channel %0d slot %0d last %0d",
                         $time, o_hop_channel, o_slot_index, o_last_slot);
                mismatch_count++;
            end else begin
                hop_want = hop_list_q.pop_front();
                if (o_hop_channel !== hop_want.chan) begin
                    $display("%0t: hop_channel expected %0d actual %0d",
                             $time, hop_want.chan, o_hop_channel);
                    mismatch_count++;
                end
                if (o_slot_index !== hop_want.slot) begin
                    $display("%0t: slot_index expected %0d actual %0d",
                             $time, hop_want.slot, o_slot_index);
                    mismatch_count++;
                end
                if (o_last_slot !== hop_want.last) begin
                    $display("%0t: last_slot expected %0d actual %0d",
                             $time, hop_want.last, o_last_slot);
                    mismatch_count++;
                end
            end
        end
    end

    // extremes, both parities and walking bits
    task automatic test_directed_ids();
        logic [31:0] ids [$];
        id_idle_pct   = 0;
        out_stall_pct = 0;
        ids = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE,
                32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                32'h1234_5678, 32'h8765_4321, 32'h0000_00FF, 32'hFF00_0000,
                32'h00FF_00FF, 32'hFF00_FF00, 32'h0000_0002, 32'hDEAD_BEEF,
                32'h0000_8000, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_FFFF};
        foreach (ids[k])
            send_id(ids[k]);
    endtask

    task automatic run_random_ids(input int n, input int idle_pct, input int stall_pct);
        id_idle_pct   = idle_pct;
        out_stall_pct = stall_pct;
        repeat (n)
            send_id($urandom);
    endtask

    task automatic test_random_no_idle();
        run_random_ids(70, 0, 0);
    endtask

    task automatic test_random_id_idle();
        run_random_ids(70, 56, 0);
    endtask

    task automatic test_random_out_stall();
        run_random_ids(70, 0, 56);
    endtask

    task automatic test_random_both_idle();
        run_random_ids(70, 9, 9);
    endtask

    // output held off long while ids keep coming, so the input stalls
    task automatic test_output_hold_fill();
        id_idle_pct   = 0;
        out_stall_pct = 0;
        hold_req = ~hold_req;
        repeat (6)
            send_id($urandom);
    endtask

    // sender waits for every list to finish, then resumes
    task automatic test_pause_until_done();
        run_random_ids(5, 0, 30);
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait_lists_done();
        run_random_ids(5, 0, 30);
    endtask

    initial begin
        // synchronous reset, released on a falling clock edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_ids();
        test_random_no_idle();
        test_random_id_idle();
        test_random_out_stall();
        test_random_both_idle();
        test_output_hold_fill();
        test_pause_until_done();

        @(negedge i_clk);
        i_valid <= 1'b0;
        wait_lists_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (hop_list_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, hop_list_q.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/hclg_pkg.sv
hdl/hclg_mul_unit.sv
hdl/hclg_reduce.sv
hdl/hop_channel_list_generator_core.sv
verif/testbench.sv
